// ----- hdl/partial_reliability_arq_sender_top_macros.svh -----
// Assertion macros shared by the checker of the ARQ sender
`ifndef PARTIAL_RELIABILITY_ARQ_SENDER_TOP_MACROS_SVH
`define PARTIAL_RELIABILITY_ARQ_SENDER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PRARQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prarq check failed");

// next-cycle implication, disabled while reset is asserted
`define PRARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prarq check failed");

`endif

// ----- hdl/prarq_pkg.sv -----
// Types, constants and microcode ROM of the partial reliability ARQ sender
package prarq_pkg;

    localparam int WINDOW_DEPTH_DFLT = 16;
    localparam int SEQ_W             = 32;
    localparam int LOSS_W            = 7;
    localparam int ACT_W             = 3;
    localparam int FILL_OUT_W        = 5;
    localparam int QCNT_W            = 3;
    localparam int PCT_SCALE         = 100;
    localparam int FILL_W_DFLT       = $clog2(WINDOW_DEPTH_DFLT + 1);

    localparam logic [LOSS_W-1:0] ACC_LOSS_RST = 7'd20;

    localparam logic FUNC_SEND = 1'b0;

    localparam logic [ACT_W-1:0] ACT_NEW    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACKED  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RETX   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ACCEPT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IGNORE = 3'd4;

    typedef struct packed {
        logic             func;
        logic             pdu_arrived;
        logic             ack_flag;
        logic [SEQ_W-1:0] ack_seq;
    } t_in_word;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [SEQ_W-1:0]      seq_out;
        logic [LOSS_W-1:0]     loss_percent;
        logic [FILL_OUT_W-1:0] window_fill;
    } t_out_word;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT_NEW,
        OP_EMIT_ACKED,
        OP_EMIT_RETX,
        OP_EMIT_ACCEPT,
        OP_EMIT_IGNORE
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_IS_SEND,
        CND_NOT_AWAIT,
        CND_AWAITING,
        CND_GOOD_ACK,
        CND_DIV_MORE,
        CND_LOSS_OK
    } t_cond;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STP_FETCH    = 4'd0;
    localparam t_step STP_DISPATCH = 4'd1;
    localparam t_step STP_AWAIT    = 4'd2;
    localparam t_step STP_ACK_CHK  = 4'd3;
    localparam t_step STP_DIV_INIT = 4'd4;
    localparam t_step STP_DIV_LOOP = 4'd5;
    localparam t_step STP_LOSS_CHK = 4'd6;
    localparam t_step STP_RETX     = 4'd7;
    localparam t_step STP_SEND_CHK = 4'd8;
    localparam t_step STP_NEW      = 4'd9;
    localparam t_step STP_ACKED    = 4'd10;
    localparam t_step STP_IGNORE   = 4'd11;
    localparam t_step STP_ACCEPT   = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  wait_in;
        logic  wait_out;
        t_step target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_op  op;
        logic exec;
        logic in_ready;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic is_send;
        logic awaiting;
        logic good_ack;
        logic div_more;
        logic loss_ok;
    } t_flags;

    typedef struct packed {
        logic init;
        logic step;
    } t_div_ctl;

    function automatic t_uword mk_uword(input t_op op, input t_cond cond, input logic wait_in,
                                        input logic wait_out, input t_step target);
        t_uword w;
        w.op       = op;
        w.cond     = cond;
        w.wait_in  = wait_in;
        w.wait_out = wait_out;
        w.target   = target;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input t_step addr);
        t_uword w;
        case (addr)
            STP_FETCH:    w = mk_uword(OP_LATCH, CND_NEVER, 1'b1, 1'b0, STP_FETCH);
            STP_DISPATCH: w = mk_uword(OP_NONE, CND_IS_SEND, 1'b0, 1'b0, STP_SEND_CHK);
            STP_AWAIT:    w = mk_uword(OP_NONE, CND_NOT_AWAIT, 1'b0, 1'b0, STP_IGNORE);
            STP_ACK_CHK:  w = mk_uword(OP_NONE, CND_GOOD_ACK, 1'b0, 1'b0, STP_ACKED);
            STP_DIV_INIT: w = mk_uword(OP_DIV_INIT, CND_NEVER, 1'b0, 1'b0, STP_FETCH);
            STP_DIV_LOOP: w = mk_uword(OP_DIV_STEP, CND_DIV_MORE, 1'b0, 1'b0, STP_DIV_LOOP);
            STP_LOSS_CHK: w = mk_uword(OP_NONE, CND_LOSS_OK, 1'b0, 1'b0, STP_ACCEPT);
            STP_RETX:     w = mk_uword(OP_EMIT_RETX, CND_ALWAYS, 1'b0, 1'b1, STP_FETCH);
            STP_SEND_CHK: w = mk_uword(OP_NONE, CND_AWAITING, 1'b0, 1'b0, STP_IGNORE);
            STP_NEW:      w = mk_uword(OP_EMIT_NEW, CND_ALWAYS, 1'b0, 1'b1, STP_FETCH);
            STP_ACKED:    w = mk_uword(OP_EMIT_ACKED, CND_ALWAYS, 1'b0, 1'b1, STP_FETCH);
            STP_IGNORE:   w = mk_uword(OP_EMIT_IGNORE, CND_ALWAYS, 1'b0, 1'b1, STP_FETCH);
            STP_ACCEPT:   w = mk_uword(OP_EMIT_ACCEPT, CND_ALWAYS, 1'b0, 1'b1, STP_FETCH);
            default:      w = mk_uword(OP_NONE, CND_ALWAYS, 1'b0, 1'b0, STP_FETCH);
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/prarq_if.sv -----
// Valid/ready channel interfaces for input and result words
interface prarq_in_if;
    logic                valid;
    logic                ready;
    prarq_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prarq_out_if;
    logic                 valid;
    logic                 ready;
    prarq_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/prarq_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps
module prarq_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prarq_pkg::t_flags  i_flags,
    output prarq_pkg::t_ctrl   o_ctrl
);

    prarq_pkg::t_step  r_pc;
    prarq_pkg::t_step  n_pc;
    prarq_pkg::t_uword w_word;
    logic              w_take;
    logic              w_hold;

    always_comb begin
        w_word = prarq_pkg::ucode_rom(r_pc);
        unique case (w_word.cond)
            prarq_pkg::CND_NEVER:     w_take = 1'b0;
            prarq_pkg::CND_ALWAYS:    w_take = 1'b1;
            prarq_pkg::CND_IS_SEND:   w_take = i_flags.is_send;
            prarq_pkg::CND_NOT_AWAIT: w_take = !i_flags.awaiting;
            prarq_pkg::CND_AWAITING:  w_take = i_flags.awaiting;
            prarq_pkg::CND_GOOD_ACK:  w_take = i_flags.good_ack;
            prarq_pkg::CND_DIV_MORE:  w_take = i_flags.div_more;
            prarq_pkg::CND_LOSS_OK:   w_take = i_flags.loss_ok;
            default:                  w_take = 1'b1;
        endcase
        // stall on an empty input or a full result slot
        w_hold = (w_word.wait_in && !i_flags.in_valid) || (w_word.wait_out && i_flags.out_busy);
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + prarq_pkg::t_step'(1);
        end
        o_ctrl.op       = w_word.op;
        o_ctrl.exec     = !w_hold;
        o_ctrl.in_ready = w_word.wait_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= prarq_pkg::STP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- hdl/prarq_div.sv -----
// Restoring divider, one quotient bit per step, for the loss percentage
module prarq_div #(
    parameter int FILL_W = prarq_pkg::FILL_W_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prarq_pkg::t_div_ctl           i_ctl,
    input  logic [FILL_W+prarq_pkg::LOSS_W-1:0] i_num,
    input  logic [FILL_W-1:0]             i_den,
    output logic [prarq_pkg::LOSS_W-1:0]  o_quo,
    output logic                          o_more
);

    localparam int NW = FILL_W + prarq_pkg::LOSS_W;

    logic [NW-1:0]                r_rem;
    logic [NW-1:0]                r_dsh;
    logic [prarq_pkg::LOSS_W-1:0] r_quo;
    logic [prarq_pkg::QCNT_W-1:0] r_cnt;
    logic                         w_ge;

    assign w_ge   = (r_rem >= r_dsh);
    assign o_quo  = r_quo;
    assign o_more = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.init) begin
            r_cnt <= prarq_pkg::QCNT_W'(prarq_pkg::LOSS_W - 1);
        end else if (i_ctl.step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - prarq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_rem <= i_num;
            r_dsh <= NW'(i_den) << (prarq_pkg::LOSS_W - 1);
            r_quo <= '0;
        end else if (i_ctl.step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[prarq_pkg::LOSS_W-2:0], w_ge};
        end
    end

endmodule

// ----- hdl/partial_reliability_arq_sender_top.sv -----
// Sender of a stop-and-wait ARQ with partial reliability: top level and datapath
//
// Input channel i_in takes one event word: func 0 sends a new packet, func 1 reports
// the outcome (PDU with ack flag and sequence, or a timeout) of the outstanding packet.
// Output channel o_out returns exactly one result word per event: action, sequence,
// loss percentage and window fill. i_cfg_we/i_cfg_data write the acceptable loss.
// A microcoded sequencer walks a small program; i_in.ready is high only at the fetch
// step, so one event is in work at a time.
// After fetch, a send runs dispatch and send check, then new or ignore; a report
// runs dispatch and await check, then ignore, or ack check, then acked for a good
// ack or else divider init, divider loop (one quotient bit per cycle), loss check and
// retransmit or accept. A new event is taken the cycle after the result is loaded.
// The result sits in an output register, so the next event is accepted while it
// waits; a later result holds at its emit step until o_out.ready frees the slot.
// Reset (synchronous, active low) clears the ack window, sequence, fill count and
// outstanding flag and sets the acceptable loss to 20.
module partial_reliability_arq_sender_top #(
    parameter int WINDOW_DEPTH = prarq_pkg::WINDOW_DEPTH_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    prarq_in_if.sink                     i_in,
    prarq_out_if.source                  o_out,
    input  logic                         i_cfg_we,
    input  logic [prarq_pkg::LOSS_W-1:0] i_cfg_data
);

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int NUM_W  = FILL_W + prarq_pkg::LOSS_W;

    prarq_pkg::t_ctrl    w_ctrl;
    prarq_pkg::t_flags   w_flags;
    prarq_pkg::t_div_ctl w_div_ctl;

    prarq_pkg::t_in_word          r_in;
    prarq_pkg::t_out_word         r_out;
    prarq_pkg::t_out_word         n_out;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [prarq_pkg::LOSS_W-1:0] r_acc_loss;
    logic [WINDOW_DEPTH-1:0]      r_ack_bits;
    logic [WINDOW_DEPTH-1:0]      n_ack_bits;
    logic [PTR_W-1:0]             r_wpos;
    logic [PTR_W-1:0]             n_wpos;
    logic [PTR_W-1:0]             w_newest;
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;
    logic [FILL_W-1:0]            r_acked;
    logic [FILL_W-1:0]            n_acked;
    logic [prarq_pkg::SEQ_W-1:0]  r_next_seq;
    logic [prarq_pkg::SEQ_W-1:0]  n_next_seq;
    logic [prarq_pkg::SEQ_W-1:0]  w_seq_inc;
    logic                         r_awaiting;
    logic                         n_awaiting;
    logic                         w_full;
    logic [NUM_W-1:0]             w_num;
    logic [prarq_pkg::LOSS_W-1:0] w_quo;
    logic [prarq_pkg::LOSS_W-1:0] w_loss;
    logic                         w_div_more;

    prarq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    prarq_div #(
        .FILL_W (FILL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num),
        .i_den   (r_fill),
        .o_quo   (w_quo),
        .o_more  (w_div_more)
    );

    assign i_in.ready  = w_ctrl.in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_seq_inc = r_next_seq + prarq_pkg::SEQ_W'(1);
    assign w_full    = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign w_newest  = (r_wpos == '0) ? PTR_W'(WINDOW_DEPTH - 1) : (r_wpos - PTR_W'(1));
    assign w_num     = NUM_W'(r_fill - r_acked) * NUM_W'(prarq_pkg::PCT_SCALE);
    // empty window reads as no loss
    assign w_loss    = (r_fill == '0) ? '0 : w_quo;

    assign w_div_ctl.init = w_ctrl.exec && (w_ctrl.op == prarq_pkg::OP_DIV_INIT);
    assign w_div_ctl.step = w_ctrl.exec && (w_ctrl.op == prarq_pkg::OP_DIV_STEP);

    always_comb begin
        w_flags.in_valid = i_in.valid;
        w_flags.out_busy = r_out_valid && !o_out.ready;
        w_flags.is_send  = (r_in.func == prarq_pkg::FUNC_SEND);
        w_flags.awaiting = r_awaiting;
        w_flags.good_ack = r_in.pdu_arrived && r_in.ack_flag && (r_in.ack_seq == w_seq_inc);
        w_flags.div_more = w_div_more;
        w_flags.loss_ok  = (w_loss <= r_acc_loss);
    end

    always_comb begin
        n_ack_bits  = r_ack_bits;
        n_wpos      = r_wpos;
        n_fill      = r_fill;
        n_acked     = r_acked;
        n_next_seq  = r_next_seq;
        n_awaiting  = r_awaiting;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_ctrl.exec) begin
            unique case (w_ctrl.op)
                prarq_pkg::OP_EMIT_NEW: begin
                    n_ack_bits[r_wpos] = 1'b0;
                    // overwriting the oldest entry drops its ack from the count
                    if (w_full && r_ack_bits[r_wpos]) begin
                        n_acked = r_acked - FILL_W'(1);
                    end
                    n_wpos = (r_wpos == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : (r_wpos + PTR_W'(1));
                    if (!w_full) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    n_awaiting         = 1'b1;
                    n_out.action       = prarq_pkg::ACT_NEW;
                    n_out.seq_out      = r_next_seq;
                    n_out.loss_percent = '0;
                    n_out.window_fill  = prarq_pkg::FILL_OUT_W'(n_fill);
                    n_out_valid        = 1'b1;
                end
                prarq_pkg::OP_EMIT_ACKED: begin
                    n_ack_bits[w_newest] = 1'b1;
                    n_acked              = r_acked + FILL_W'(1);
                    n_next_seq           = w_seq_inc;
                    n_awaiting           = 1'b0;
                    n_out.action         = prarq_pkg::ACT_ACKED;
                    n_out.seq_out        = w_seq_inc;
                    n_out.loss_percent   = '0;
                    n_out.window_fill    = prarq_pkg::FILL_OUT_W'(r_fill);
                    n_out_valid          = 1'b1;
                end
                prarq_pkg::OP_EMIT_RETX: begin
                    n_out.action       = prarq_pkg::ACT_RETX;
                    n_out.seq_out      = r_next_seq;
                    n_out.loss_percent = w_loss;
                    n_out.window_fill  = prarq_pkg::FILL_OUT_W'(r_fill);
                    n_out_valid        = 1'b1;
                end
                prarq_pkg::OP_EMIT_ACCEPT: begin
                    n_awaiting         = 1'b0;
                    n_out.action       = prarq_pkg::ACT_ACCEPT;
                    n_out.seq_out      = r_next_seq;
                    n_out.loss_percent = w_loss;
                    n_out.window_fill  = prarq_pkg::FILL_OUT_W'(r_fill);
                    n_out_valid        = 1'b1;
                end
                prarq_pkg::OP_EMIT_IGNORE: begin
                    n_out.action       = prarq_pkg::ACT_IGNORE;
                    n_out.seq_out      = r_next_seq;
                    n_out.loss_percent = '0;
                    n_out.window_fill  = prarq_pkg::FILL_OUT_W'(r_fill);
                    n_out_valid        = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_bits  <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_acked     <= '0;
            r_next_seq  <= '0;
            r_awaiting  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_loss  <= prarq_pkg::ACC_LOSS_RST;
        end else begin
            r_ack_bits  <= n_ack_bits;
            r_wpos      <= n_wpos;
            r_fill      <= n_fill;
            r_acked     <= n_acked;
            r_next_seq  <= n_next_seq;
            r_awaiting  <= n_awaiting;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_acc_loss <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_ctrl.exec && (w_ctrl.op == prarq_pkg::OP_LATCH)) begin
            r_in <= i_in.data;
        end
    end

endmodule

// ----- hdl/prarq_chk.sv -----
// Port-level checker of the ARQ sender, bound to the top level
`include "partial_reliability_arq_sender_top_macros.svh"

module prarq_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input prarq_pkg::t_out_word i_out_data
);

    logic w_in_fire;
    logic w_lossy;

    assign w_in_fire = i_in_valid && i_in_ready;
    assign w_lossy   = (i_out_data.action == prarq_pkg::ACT_RETX)
                    || (i_out_data.action == prarq_pkg::ACT_ACCEPT);

    `PRARQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    `PRARQ_ASSERT_IMPLY(a_loss_zero, i_clk, i_rst_n, i_out_valid && !w_lossy, i_out_data.loss_percent == '0)

    // a retransmit means the loss exceeded the limit, so it cannot be zero
    `PRARQ_ASSERT_IMPLY(a_retx_loss, i_clk, i_rst_n, i_out_valid && (i_out_data.action == prarq_pkg::ACT_RETX), i_out_data.loss_percent != '0)

    // no result can be produced in the cycle right after an accept
    `PRARQ_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, w_in_fire, !$rose(i_out_valid))

endmodule

bind partial_reliability_arq_sender_top prarq_chk u_prarq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
